>>> hdl/gyro_yaw_integrator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the yaw integrator
// Short forms for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef GYRO_YAW_INTEGRATOR_MACROS_SVH
`define GYRO_YAW_INTEGRATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GYI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When cond holds, sig must keep its value into the next cycle.
`define GYI_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

>>> hdl/gyi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw integrator package
// Field widths, register indexes, reset values and the multiplier interface.
// ----------------------------------------------------------------------------
package gyi_pkg;

    // Field widths
    localparam int RAW_W      = 16;
    localparam int REQ_W      = 2;
    localparam int RATE_W     = 19;
    localparam int YAW_OUT_W  = 25;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - (RATE_W + YAW_OUT_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Serial multiplier: signed A by unsigned B, one 4-bit digit of B a cycle
    localparam int MUL_A_W     = 20;
    localparam int MUL_B_W     = 24;
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int PROD_W      = MUL_A_W + 1 + MUL_B_W;

    // Intermediate rate width, wide enough for scaling, bias and negation
    localparam int TMP_W = 22;

    localparam logic signed [TMP_W-1:0] RATE_MAX_T = 22'sd262143;
    localparam logic signed [TMP_W-1:0] RATE_MIN_T = -22'sd262144;
    localparam logic [16:0]             ALPHA_ONE  = 17'd65536;

    // Rounding of Q16 products
    localparam int                       RND_SHIFT  = 16;
    localparam logic signed [PROD_W-1:0] RND16_BIAS = PROD_W'(32768);

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESET  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_PER_LSB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_BIAS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SIGN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SECONDS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_TARGET  = 3'd7;

    // Register reset values
    localparam logic [19:0]        RST_RATE_PER_LSB = 20'd256111;
    localparam logic signed [17:0] RST_GYRO_BIAS    = 18'sd0;
    localparam logic               RST_INVERT_SIGN  = 1'b0;
    localparam logic [16:0]        RST_FILTER_ALPHA = 17'd13107;
    localparam logic [15:0]        RST_DEAD_ZONE    = 16'd128;
    localparam logic [23:0]        RST_STEP_SECONDS = 24'd134218;
    localparam logic [23:0]        RST_MAX_STEP     = 24'd327680;
    localparam logic [23:0]        RST_TURN_TARGET  = 24'd5898240;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

>>> hdl/gyi_serial_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed by unsigned product, one 4-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module gyi_serial_mult (
    input  logic              aclk,
    input  logic              aresetn,
    input  gyi_pkg::mul_req_t req,
    output gyi_pkg::mul_rsp_t rsp
);

    localparam int AW = gyi_pkg::MUL_A_W;
    localparam int BW = gyi_pkg::MUL_B_W;
    localparam int DW = gyi_pkg::MUL_DIGIT_W;
    localparam int CW = gyi_pkg::MUL_CNT_W;
    localparam int PW = AW + DW + 1;

    logic signed [AW-1:0] a_reg;
    logic signed [AW:0]   hi_reg, hi_next;
    logic [BW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [PW-1:0] partial;
    logic signed [PW-1:0] acc;

    // The upper half accumulates A times the current digit, then the whole
    // product word moves down by one digit; B leaves through the low end.
    always_comb begin
        partial = a_reg * $signed({1'b0, lo_reg[DW-1:0]});
        acc     = {{DW{hi_reg[AW]}}, hi_reg} + partial;
        hi_next = acc[PW-1:DW];
        lo_next = {acc[DW-1:0], lo_reg[BW-1:DW]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(gyi_pkg::MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg, lo_reg};

endmodule

>>> hdl/gyro_yaw_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro yaw integrator
// Scales, filters and dead-zones Z gyro samples and integrates them into yaw.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the s_ channel: s_tuser carries the request kind
// (sample, reset of yaw and filter, or mark of the turn start) and s_tdata the
// raw signed gyro count. Every accepted item gives exactly one result item on
// the m_ channel with the reported rate, the yaw angle and the turn flag.
// Registers are written through the cfg_ channel, which is always ready; write
// them only while no item is in flight.
// Sequencing. One item is worked on at a time. A reset, mark or unused request
// goes through the turn difference and wrap steps to the output. A sample passes
// up to three times through the 4-bit digit-serial multiplier (scaling, filter,
// step), with add and compare steps between them; the filter product is skipped
// when the filter is loaded directly, and the step product when the filtered rate
// is zero or falls in the dead zone.
// The result sits in an output register, so a stalled receiver holds only the
// final step; s_tready returns once the result has been loaded.
// Reset clears yaw, turn start, filter and reported rate, loads the register
// defaults and leaves the output channel empty.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator #(
    parameter int RATE_FRAC_BITS  = 8,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gyi_pkg::RAW_W-1:0]           s_tdata,   // [15:0] gyro_raw
    input  logic [gyi_pkg::REQ_W-1:0]           s_tuser,   // [1:0] req_type
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gyi_pkg::OUT_DATA_W-1:0]      m_tdata,   // [18:0] rate_out,
                                                           // [43:19] yaw_out,
                                                           // [44] turn_reached
    // Register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gyi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gyi_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = gyi_pkg::MUL_A_W;
    localparam int BW = gyi_pkg::MUL_B_W;
    localparam int PW = gyi_pkg::PROD_W;
    localparam int TW = gyi_pkg::TMP_W;
    localparam int RW = gyi_pkg::RATE_W;

    // Yaw holds +-180 degrees; sums and differences need one bit more.
    localparam int YAW_W      = ANGLE_FRAC_BITS + 9;
    localparam int STEP_SHIFT = 24 + RATE_FRAC_BITS - ANGLE_FRAC_BITS;

    localparam logic signed [YAW_W:0] HALF_TURN =
        (YAW_W + 1)'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [YAW_W:0] FULL_TURN =
        (YAW_W + 1)'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic signed [PW-1:0] STEP_RND = PW'(2 ** (STEP_SHIFT - 1));

    // Sequencer states
    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_MUL_SCALE  = 5'd1;
    localparam logic [4:0] ST_SC_ROUND   = 5'd2;
    localparam logic [4:0] ST_SC_BIAS    = 5'd3;
    localparam logic [4:0] ST_SC_SAT     = 5'd4;
    localparam logic [4:0] ST_F_START    = 5'd5;
    localparam logic [4:0] ST_MUL_FILT   = 5'd6;
    localparam logic [4:0] ST_F_ROUND    = 5'd7;
    localparam logic [4:0] ST_F_ADD      = 5'd8;
    localparam logic [4:0] ST_DEAD_ZONE  = 5'd9;
    localparam logic [4:0] ST_MUL_STEP   = 5'd10;
    localparam logic [4:0] ST_STEP_ROUND = 5'd11;
    localparam logic [4:0] ST_STEP_CLAMP = 5'd12;
    localparam logic [4:0] ST_YAW_ADD    = 5'd13;
    localparam logic [4:0] ST_YAW_WRAP   = 5'd14;
    localparam logic [4:0] ST_TURN_DIFF  = 5'd15;
    localparam logic [4:0] ST_TURN_WRAP  = 5'd16;
    localparam logic [4:0] ST_EMIT       = 5'd17;

    logic [4:0] state_reg, state_next;

    // Configuration registers
    logic [19:0]        rate_per_lsb_reg;
    logic signed [17:0] gyro_bias_reg;
    logic               invert_sign_reg;
    logic [16:0]        filter_alpha_reg;
    logic [15:0]        dead_zone_reg;
    logic [23:0]        step_seconds_reg;
    logic [23:0]        max_step_reg;
    logic [23:0]        turn_target_reg;

    // Architectural state
    logic signed [RW-1:0]    filt_reg, filt_next;
    logic                    primed_reg, primed_next;
    logic signed [RW-1:0]    rpt_reg, rpt_next;
    logic signed [YAW_W-1:0] yaw_reg, yaw_next;
    logic signed [YAW_W-1:0] start_reg, start_next;

    // Working registers
    logic signed [TW-1:0]    tmp_reg, tmp_next;
    logic signed [RW-1:0]    cur_rate_reg, cur_rate_next;
    logic signed [PW-1:0]    srnd_reg, srnd_next;
    logic signed [YAW_W:0]   lim_reg, lim_next;
    logic signed [YAW_W:0]   step_reg, step_next;
    logic signed [YAW_W:0]   sum_reg, sum_next;

    // Output register
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [gyi_pkg::OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    gyi_pkg::mul_req_t mul_req;
    gyi_pkg::mul_rsp_t mul_rsp;

    // Datapath helpers
    logic                     s_accept;
    logic                     out_free;
    logic signed [PW-1:0]     prod_s;
    logic signed [PW-1:0]     rnd16_sum, rnd16;
    logic signed [PW-1:0]     step_sum, step_shr;
    logic signed [TW-1:0]     bias_ext;
    logic signed [RW-1:0]     sat_rate;
    logic signed [AW-1:0]     rate_diff;
    logic [16:0]              alpha_eff;
    logic signed [RW+1:0]     filt_w, dz_w;
    logic                     in_dead;
    logic signed [PW-1:0]     max_ext, half_ext, lim_ext;
    logic signed [YAW_W:0]    wrapped;
    logic signed [YAW_W:0]    abs_diff;
    logic signed [PW-1:0]     abs_ext, tgt_ext;
    logic                     reached;

    gyi_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        prod_s    = mul_rsp.prod;
        rnd16_sum = prod_s + gyi_pkg::RND16_BIAS;
        rnd16     = rnd16_sum >>> gyi_pkg::RND_SHIFT;
        step_sum  = prod_s + STEP_RND;
        step_shr  = step_sum >>> STEP_SHIFT;

        bias_ext  = TW'(gyro_bias_reg);
        if (tmp_reg > gyi_pkg::RATE_MAX_T) begin
            sat_rate = RW'(gyi_pkg::RATE_MAX_T);
        end else if (tmp_reg < gyi_pkg::RATE_MIN_T) begin
            sat_rate = RW'(gyi_pkg::RATE_MIN_T);
        end else begin
            sat_rate = tmp_reg[RW-1:0];
        end

        rate_diff = AW'(cur_rate_reg) - AW'(filt_reg);
        alpha_eff = (filter_alpha_reg > gyi_pkg::ALPHA_ONE) ? gyi_pkg::ALPHA_ONE
                                                            : filter_alpha_reg;

        // Rates strictly inside the dead zone are forced to zero.
        filt_w  = (RW + 2)'(filt_reg);
        dz_w    = (RW + 2)'(dead_zone_reg);
        in_dead = (filt_w > -dz_w) && (filt_w < dz_w);

        // The step limit never exceeds half a turn, so one wrap is enough.
        max_ext  = PW'(max_step_reg);
        half_ext = PW'(HALF_TURN);
        lim_ext  = PW'(lim_reg);

        if (sum_reg > HALF_TURN) begin
            wrapped = sum_reg - FULL_TURN;
        end else if (sum_reg < -HALF_TURN) begin
            wrapped = sum_reg + FULL_TURN;
        end else begin
            wrapped = sum_reg;
        end

        abs_diff = sum_reg[YAW_W] ? -sum_reg : sum_reg;
        abs_ext  = PW'(abs_diff);
        tgt_ext  = PW'(turn_target_reg);
        reached  = (abs_ext >= tgt_ext);
    end

    always_comb begin
        state_next    = state_reg;
        filt_next     = filt_reg;
        primed_next   = primed_reg;
        rpt_next      = rpt_reg;
        yaw_next      = yaw_reg;
        start_next    = start_reg;
        tmp_next      = tmp_reg;
        cur_rate_next = cur_rate_reg;
        srnd_next     = srnd_reg;
        lim_next      = lim_reg;
        step_next     = step_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        mul_req.start = 1'b0;
        mul_req.a     = AW'($signed(s_tdata));
        mul_req.b     = BW'(rate_per_lsb_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        gyi_pkg::REQ_SAMPLE: begin
                            mul_req.start = 1'b1;
                            state_next    = ST_MUL_SCALE;
                        end
                        gyi_pkg::REQ_RESET: begin
                            yaw_next    = '0;
                            filt_next   = '0;
                            primed_next = 1'b0;
                            state_next  = ST_TURN_DIFF;
                        end
                        gyi_pkg::REQ_MARK: begin
                            start_next = yaw_reg;
                            state_next = ST_TURN_DIFF;
                        end
                        default: begin
                            state_next = ST_TURN_DIFF;
                        end
                    endcase
                end
            end
            ST_MUL_SCALE: begin
                if (mul_rsp.done) begin
                    state_next = ST_SC_ROUND;
                end
            end
            ST_SC_ROUND: begin
                tmp_next   = rnd16[TW-1:0];
                state_next = ST_SC_BIAS;
            end
            ST_SC_BIAS: begin
                tmp_next   = invert_sign_reg ? (bias_ext - tmp_reg) : (tmp_reg - bias_ext);
                state_next = ST_SC_SAT;
            end
            ST_SC_SAT: begin
                cur_rate_next = sat_rate;
                if (primed_reg) begin
                    state_next = ST_F_START;
                end else begin
                    // First sample after reset loads the filter directly.
                    filt_next   = sat_rate;
                    primed_next = 1'b1;
                    state_next  = ST_DEAD_ZONE;
                end
            end
            ST_F_START: begin
                mul_req.start = 1'b1;
                mul_req.a     = rate_diff;
                mul_req.b     = BW'(alpha_eff);
                state_next    = ST_MUL_FILT;
            end
            ST_MUL_FILT: begin
                if (mul_rsp.done) begin
                    state_next = ST_F_ROUND;
                end
            end
            ST_F_ROUND: begin
                tmp_next   = rnd16[TW-1:0];
                state_next = ST_F_ADD;
            end
            ST_F_ADD: begin
                filt_next  = filt_reg + $signed(tmp_reg[RW-1:0]);
                state_next = ST_DEAD_ZONE;
            end
            ST_DEAD_ZONE: begin
                if (in_dead) begin
                    rpt_next = '0;
                end else begin
                    rpt_next = filt_reg;
                end
                if (!in_dead && (filt_reg != '0)) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = AW'(filt_reg);
                    mul_req.b     = BW'(step_seconds_reg);
                    state_next    = ST_MUL_STEP;
                end else begin
                    state_next = ST_TURN_DIFF;
                end
            end
            ST_MUL_STEP: begin
                if (mul_rsp.done) begin
                    state_next = ST_STEP_ROUND;
                end
            end
            ST_STEP_ROUND: begin
                srnd_next = step_shr;
                if (max_ext > half_ext) begin
                    lim_next = HALF_TURN;
                end else begin
                    lim_next = (YAW_W + 1)'(max_step_reg);
                end
                state_next = ST_STEP_CLAMP;
            end
            ST_STEP_CLAMP: begin
                if (srnd_reg > lim_ext) begin
                    step_next = lim_reg;
                end else if (srnd_reg < -lim_ext) begin
                    step_next = -lim_reg;
                end else begin
                    step_next = srnd_reg[YAW_W:0];
                end
                state_next = ST_YAW_ADD;
            end
            ST_YAW_ADD: begin
                sum_next   = (YAW_W + 1)'(yaw_reg) + step_reg;
                state_next = ST_YAW_WRAP;
            end
            ST_YAW_WRAP: begin
                yaw_next   = wrapped[YAW_W-1:0];
                state_next = ST_TURN_DIFF;
            end
            ST_TURN_DIFF: begin
                sum_next   = (YAW_W + 1)'(yaw_reg) - (YAW_W + 1)'(start_reg);
                state_next = ST_TURN_WRAP;
            end
            ST_TURN_WRAP: begin
                sum_next   = wrapped;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{gyi_pkg::OUT_PAD_W{1'b0}}, reached,
                                     gyi_pkg::YAW_OUT_W'(yaw_reg), rpt_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            filt_reg     <= '0;
            primed_reg   <= 1'b0;
            rpt_reg      <= '0;
            yaw_reg      <= '0;
            start_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            filt_reg     <= filt_next;
            primed_reg   <= primed_next;
            rpt_reg      <= rpt_next;
            yaw_reg      <= yaw_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg      <= tmp_next;
        cur_rate_reg <= cur_rate_next;
        srnd_reg     <= srnd_next;
        lim_reg      <= lim_next;
        step_reg     <= step_next;
        sum_reg      <= sum_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_per_lsb_reg <= gyi_pkg::RST_RATE_PER_LSB;
            gyro_bias_reg    <= gyi_pkg::RST_GYRO_BIAS;
            invert_sign_reg  <= gyi_pkg::RST_INVERT_SIGN;
            filter_alpha_reg <= gyi_pkg::RST_FILTER_ALPHA;
            dead_zone_reg    <= gyi_pkg::RST_DEAD_ZONE;
            step_seconds_reg <= gyi_pkg::RST_STEP_SECONDS;
            max_step_reg     <= gyi_pkg::RST_MAX_STEP;
            turn_target_reg  <= gyi_pkg::RST_TURN_TARGET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gyi_pkg::CFG_RATE_PER_LSB: rate_per_lsb_reg <= cfg_data[19:0];
                gyi_pkg::CFG_GYRO_BIAS:    gyro_bias_reg    <= $signed(cfg_data[17:0]);
                gyi_pkg::CFG_INVERT_SIGN:  invert_sign_reg  <= cfg_data[0];
                gyi_pkg::CFG_FILTER_ALPHA: filter_alpha_reg <= cfg_data[16:0];
                gyi_pkg::CFG_DEAD_ZONE:    dead_zone_reg    <= cfg_data[15:0];
                gyi_pkg::CFG_STEP_SECONDS: step_seconds_reg <= cfg_data[23:0];
                gyi_pkg::CFG_MAX_STEP:     max_step_reg     <= cfg_data[23:0];
                gyi_pkg::CFG_TURN_TARGET:  turn_target_reg  <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/gyi_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Yaw integrator port checker
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "gyro_yaw_integrator_macros.svh"

module gyi_port_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gyi_pkg::OUT_DATA_W-1:0]   m_tdata
);

    `GYI_ASSERT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result withdrawn while stalled")
    `GYI_ASSERT_HOLD(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready, m_tdata, "stalled result changed")
    `GYI_ASSERT(a_one_item_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
    `GYI_ASSERT(a_result_from_work, aclk, aresetn, $rose(m_tvalid) |-> !$past(s_tready), "result appeared without an item in flight")

endmodule

bind gyro_yaw_integrator gyi_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro yaw integrator testbench
// Drives request items into the integrator through a queue-fed driver and
// checks every result item against a cycle-free predictor of rate, yaw and the
// turn flag. The run goes through default, extreme and random register
// settings, random gaps on both channels, one long receiver hold-off and a
// stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_top;
    import gyi_pkg::*;

    localparam int  ANGLE_FRAC  = 16;
    localparam int  RATE_FRAC   = 8;
    localparam int  STEP_SHIFT  = 24 + RATE_FRAC - ANGLE_FRAC;
    localparam longint HALF_TURN = longint'(180) <<< ANGLE_FRAC;
    localparam longint FULL_TURN = longint'(360) <<< ANGLE_FRAC;
    localparam longint RATE_HI  = 262143;
    localparam longint RATE_LO  = -262144;

    // The spare request kind does nothing but still returns a result.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_AFTER  = 250;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 64;
    localparam int MAX_PRINTS  = 60;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [RAW_W-1:0] raw;
    } gyro_req_t;

    typedef struct {
        logic [RATE_W-1:0]    rate;
        logic [YAW_OUT_W-1:0] yaw;
        logic                 reached;
    } yaw_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RAW_W-1:0]      s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    gyro_req_t   req_queue[$];
    yaw_result_t exp_results[$];

    // Predictor copy of the registers.
    logic [19:0]        r_rate_per_lsb = RST_RATE_PER_LSB;
    logic signed [17:0] r_gyro_bias    = RST_GYRO_BIAS;
    logic               r_invert_sign  = RST_INVERT_SIGN;
    logic [16:0]        r_filter_alpha = RST_FILTER_ALPHA;
    logic [15:0]        r_dead_zone    = RST_DEAD_ZONE;
    logic [23:0]        r_step_seconds = RST_STEP_SECONDS;
    logic [23:0]        r_max_step     = RST_MAX_STEP;
    logic [23:0]        r_turn_target  = RST_TURN_TARGET;

    // Predictor copy of the integrator state.
    longint est_filtered   = 0;
    bit     est_primed     = 1'b0;
    longint est_rate       = 0;
    longint est_yaw        = 0;
    longint est_turn_start = 0;

    int  error_count  = 0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_used    = 1'b0;
    bit  idle_en      = 1'b1;
    bit  in_fire      = 1'b0;
    bit  out_fire;
    bit  cfg_fire;
    gyro_req_t   seen_req;
    gyro_req_t   next_req;
    yaw_result_t want;

    gyro_yaw_integrator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    task automatic flag_error(string msg);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR: %s", msg);
        end
        error_count++;
    endtask

    // Round to nearest, ties upwards, by an arithmetic shift.
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint wrap_half_turn(longint a);
        if (a > HALF_TURN) begin
            return a - FULL_TURN;
        end else if (a < -HALF_TURN) begin
            return a + FULL_TURN;
        end
        return a;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_RATE_PER_LSB: r_rate_per_lsb = value[19:0];
            CFG_GYRO_BIAS:    r_gyro_bias    = value[17:0];
            CFG_INVERT_SIGN:  r_invert_sign  = value[0];
            CFG_FILTER_ALPHA: r_filter_alpha = value[16:0];
            CFG_DEAD_ZONE:    r_dead_zone    = value[15:0];
            CFG_STEP_SECONDS: r_step_seconds = value;
            CFG_MAX_STEP:     r_max_step     = value;
            CFG_TURN_TARGET:  r_turn_target  = value;
            default: ;
        endcase
    endfunction

    // Advances the predicted state by one request and returns its result.
    function automatic yaw_result_t predict_yaw(gyro_req_t rq);
        longint      rate;
        longint      alpha;
        longint      dz;
        longint      lim;
        longint      step;
        longint      d;
        yaw_result_t res;
        case (rq.kind)
            REQ_SAMPLE: begin
                rate = round_shift(longint'($signed(rq.raw)) * longint'(r_rate_per_lsb),
                                   RND_SHIFT);
                rate = rate - longint'(r_gyro_bias);
                if (r_invert_sign) begin
                    rate = -rate;
                end
                if (rate > RATE_HI) rate = RATE_HI;
                if (rate < RATE_LO) rate = RATE_LO;
                // An alpha above one weighs the new sample fully.
                alpha = (r_filter_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE)
                                                     : longint'(r_filter_alpha);
                if (!est_primed) begin
                    est_filtered = rate;
                    est_primed   = 1'b1;
                end else begin
                    est_filtered += round_shift(alpha * (rate - est_filtered), RND_SHIFT);
                end
                dz       = longint'(r_dead_zone);
                est_rate = (est_filtered > -dz && est_filtered < dz) ? 0 : est_filtered;
                if (est_rate != 0) begin
                    lim = longint'(r_max_step);
                    if (lim > HALF_TURN) lim = HALF_TURN;
                    step = round_shift(est_rate * longint'(r_step_seconds), STEP_SHIFT);
                    if (step > lim) begin
                        step = lim;
                    end else if (step < -lim) begin
                        step = -lim;
                    end
                    est_yaw = wrap_half_turn(est_yaw + step);
                end
            end
            REQ_RESET: begin
                // The reported rate and the turn start survive a reset request.
                est_yaw      = 0;
                est_filtered = 0;
                est_primed   = 1'b0;
            end
            REQ_MARK: est_turn_start = est_yaw;
            default: ;
        endcase
        d = est_yaw - est_turn_start;
        if (d > HALF_TURN) d -= FULL_TURN;
        if (d < -HALF_TURN) d += FULL_TURN;
        if (d < 0) d = -d;
        res.rate    = est_rate[RATE_W-1:0];
        res.yaw     = est_yaw[YAW_OUT_W-1:0];
        res.reached = (d >= longint'(r_turn_target));
        return res;
    endfunction

    // Handshakes are sampled here, at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire      = 1'b0;
            quiet_cycles = 0;
        end else begin
            in_fire  = s_tvalid && s_tready;
            out_fire = m_tvalid && m_tready;
            cfg_fire = cfg_valid && cfg_ready;
            if (out_fire) begin
                results_seen++;
                if (exp_results.size() == 0) begin
                    flag_error($sformatf("result item with none expected: %h", m_tdata));
                end else begin
                    want = exp_results.pop_front();
                    if (m_tdata[RATE_W-1:0] !== want.rate) begin
                        flag_error($sformatf("rate_out %0d, expected %0d",
                                             $signed(m_tdata[RATE_W-1:0]),
                                             $signed(want.rate)));
                    end
                    if (m_tdata[RATE_W +: YAW_OUT_W] !== want.yaw) begin
                        flag_error($sformatf("yaw_out %0d, expected %0d",
                                             $signed(m_tdata[RATE_W +: YAW_OUT_W]),
                                             $signed(want.yaw)));
                    end
                    if (m_tdata[RATE_W + YAW_OUT_W] !== want.reached) begin
                        flag_error($sformatf("turn_reached %b, expected %b",
                                             m_tdata[RATE_W + YAW_OUT_W], want.reached));
                    end
                end
            end
            if (in_fire) begin
                seen_req.kind = s_tuser;
                seen_req.raw  = s_tdata;
                exp_results.push_back(predict_yaw(seen_req));
            end
            if (cfg_fire) begin
                apply_register(cfg_index, cfg_data);
            end
            quiet_cycles = (in_fire || out_fire || cfg_fire) ? 0 : quiet_cycles + 1;
        end
    end

    // Request driver: a valid item is held until it has been accepted.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (req_queue.size() != 0 && !(idle_en && $urandom_range(0, 99) < 25)) begin
                next_req = req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.kind;
                s_tdata  <= next_req.raw;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. Once, partway through the run, it holds off for a long
    // stretch so that the integrator backs up and stalls its request channel.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_used && results_seen >= HOLD_AFTER) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_en && $urandom_range(0, 99) < 25);
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    task automatic add_request(logic [REQ_W-1:0] kind, logic [RAW_W-1:0] raw);
        gyro_req_t rq;
        rq.kind = kind;
        rq.raw  = raw;
        req_queue.push_back(rq);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_registers(logic [CFG_DATA_W-1:0] rate_per_lsb,
                                     logic [CFG_DATA_W-1:0] gyro_bias,
                                     logic [CFG_DATA_W-1:0] invert_sign,
                                     logic [CFG_DATA_W-1:0] filter_alpha,
                                     logic [CFG_DATA_W-1:0] dead_zone,
                                     logic [CFG_DATA_W-1:0] step_seconds,
                                     logic [CFG_DATA_W-1:0] max_step,
                                     logic [CFG_DATA_W-1:0] turn_target);
        write_register(CFG_RATE_PER_LSB, rate_per_lsb);
        write_register(CFG_GYRO_BIAS, gyro_bias);
        write_register(CFG_INVERT_SIGN, invert_sign);
        write_register(CFG_FILTER_ALPHA, filter_alpha);
        write_register(CFG_DEAD_ZONE, dead_zone);
        write_register(CFG_STEP_SECONDS, step_seconds);
        write_register(CFG_MAX_STEP, max_step);
        write_register(CFG_TURN_TARGET, turn_target);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_random_registers();
        int bias;
        bias = int'($urandom_range(0, 8000)) - 4000;
        program_registers($urandom_range(0, 20'hFFFFF), CFG_DATA_W'(bias),
                          $urandom_range(0, 1), $urandom_range(0, 70000),
                          $urandom_range(0, 3000), $urandom_range(0, 3000000),
                          $urandom_range(0, 2000000), $urandom_range(0, 11796480));
    endtask

    // Runs of samples around a common level so that the filter settles and
    // the yaw travels far enough to wrap and to reach the turn target, with
    // resets, marks, spare requests and stray samples mixed in.
    task automatic queue_motion(int count);
        int n;
        int len;
        int base;
        int raw_v;
        int roll;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 3))
                0: base = int'($signed(16'($urandom)));
                1: base = int'($urandom_range(0, 800)) - 400;
                2: base = $urandom_range(0, 1) ? 32767 : -32768;
                default: base = int'($urandom_range(0, 16000)) - 8000;
            endcase
            len = $urandom_range(3, 40);
            for (int k = 0; k < len && n < count; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    add_request(REQ_RESET, 16'($urandom));
                    n++;
                end else if (roll < 9) begin
                    add_request(REQ_MARK, 16'($urandom));
                    n++;
                end else if (roll < 12) begin
                    add_request(REQ_SPARE, 16'($urandom));
                end else if (roll < 20) begin
                    add_request(REQ_SAMPLE, 16'($urandom));
                    n++;
                end else begin
                    raw_v = base + int'($urandom_range(0, 200)) - 100;
                    if (raw_v > 32767) raw_v = 32767;
                    if (raw_v < -32768) raw_v = -32768;
                    add_request(REQ_SAMPLE, 16'(raw_v));
                    n++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || s_tvalid || exp_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset defaults: the first sample loads the
        // filter, then extremes, a mark, the spare kind and a reset request
        // followed by a sample that loads the filter again.
        add_request(REQ_SAMPLE, 16'h0000);
        add_request(REQ_SAMPLE, 16'h7FFF);
        add_request(REQ_SAMPLE, 16'h7FFF);
        add_request(REQ_SAMPLE, 16'h8000);
        add_request(REQ_SAMPLE, 16'h8000);
        add_request(REQ_SAMPLE, 16'h0001);
        add_request(REQ_SAMPLE, 16'hFFFF);
        add_request(REQ_MARK, 16'h0000);
        repeat (6) add_request(REQ_SAMPLE, 16'h7FFF);
        add_request(REQ_SPARE, 16'hFFFF);
        add_request(REQ_RESET, 16'h5555);
        add_request(REQ_SAMPLE, 16'h8000);
        add_request(REQ_SAMPLE, 16'h0000);
        add_request(REQ_MARK, 16'hAAAA);
        add_request(REQ_SAMPLE, 16'h5555);
        add_request(REQ_SAMPLE, 16'hAAAA);
        wait_drained();

        queue_motion(100);
        wait_drained();

        // Every register at the top of its width: alpha above one, a step
        // limit above half a turn and a target that can never be reached.
        program_registers(24'hFFFFF, 24'h1FFFF, 24'h1, 24'h1FFFF,
                          24'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        queue_motion(80);
        wait_drained();

        // Every register at its bottom: no dead zone and a zero target.
        program_registers(24'h0, 24'h20000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
        queue_motion(80);
        wait_drained();

        // A long stretch with no gaps on either side.
        idle_en = 1'b0;
        program_random_registers();
        queue_motion(100);
        wait_drained();
        idle_en = 1'b1;

        repeat (2) begin
            program_random_registers();
            queue_motion(100);
            wait_drained();
        end

        program_registers(RST_RATE_PER_LSB, 24'h0, 24'h0, RST_FILTER_ALPHA, RST_DEAD_ZONE,
                          RST_STEP_SECONDS, RST_MAX_STEP, RST_TURN_TARGET);
        queue_motion(60);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (exp_results.size() != 0) begin
            flag_error($sformatf("%0d result items never arrived", exp_results.size()));
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
